// File: rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned NSLOT = 4;      // most words one input byte can cause
  localparam int unsigned CNT_W = 3;      // holds 0..NSLOT

  localparam logic [15:0] MAX_UNITS_RST = 16'd383;
  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [20:0] MAX_CP        = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;   // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;   // 0xDC00 >> 10

  typedef struct packed {
    logic        text_end;
    logic        run_last;
    logic        unit_valid;
    logic [15:0] code_unit;
  } res_t;

  typedef res_t [NSLOT-1:0] res_vec_t;

endpackage

`default_nettype wire

// File: rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence decoder: buffers lead and continuation bits, turns one byte into
// up to four result words and applies the per-text word limit.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             advance,
  input  wire logic [7:0]                       byte_in,
  input  wire logic                             is_last,
  input  wire logic [15:0]                      max_units,
  output u8u16_pkg::res_vec_t                   res,
  output logic [u8u16_pkg::CNT_W-1:0]           res_cnt
);

  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    SK_SINGLE = 2'd0,
    SK_HI     = 2'd1,
    SK_LO     = 2'd2
  } slot_kind_t;

  logic [1:0]  pend_r, pend_nxt;
  logic [2:0]  exp_r, exp_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [15:0] units_r, units_nxt;
  logic        stop_r, stop_nxt;

  logic        is_end;
  logic [2:0]  kept;

  always_comb begin
    logic        is_cont;
    logic [20:0] acc;
    logic [2:0]  pend_inc;
    logic [1:0]  lead_cnt;
    logic [1:0]  trail_cnt;
    logic        has_mid;
    logic [20:0] mid_cp;
    logic        mid_bad;
    logic        mid_pair;
    logic [1:0]  mid_len;
    logic [19:0] supp;
    logic [15:0] mid_single;
    logic [1:0]  pend_new;
    logic [2:0]  exp_new;
    logic [20:0] cp_new;
    logic [2:0]  slot_n;
    logic [2:0]  idx;
    logic [2:0]  rel;
    logic [15:0] slot_unit [NSLOT];
    slot_kind_t  slot_kind [NSLOT];
    logic [15:0] cnt;
    logic        stp;

    is_cont  = (byte_in[7:6] == 2'b10);
    acc      = {cp_r[14:0], byte_in[5:0]};
    pend_inc = {1'b0, pend_r} + 3'd1;
    lead_cnt = 2'd0;
    has_mid  = 1'b0;
    mid_cp   = 21'd0;
    pend_new = pend_r;
    exp_new  = exp_r;
    cp_new   = cp_r;
    is_end   = 1'b0;

    if (byte_in == 8'h00) begin
      // zero byte: flush what is pending and close the text
      lead_cnt = pend_r;
      pend_new = 2'd0;
      exp_new  = 3'd0;
      cp_new   = 21'd0;
      is_end   = 1'b1;
    end else begin
      if ((pend_r != 2'd0) && is_cont) begin
        if (pend_inc >= exp_r) begin
          has_mid  = 1'b1;
          mid_cp   = acc;
          pend_new = 2'd0;
          exp_new  = 3'd0;
          cp_new   = 21'd0;
        end else begin
          pend_new = pend_inc[1:0];
          cp_new   = acc;
        end
      end else begin
        // broken sequence: one replacement per pending byte, then restart
        lead_cnt = pend_r;
        pend_new = 2'd0;
        exp_new  = 3'd0;
        cp_new   = 21'd0;
        if (!byte_in[7]) begin
          has_mid = 1'b1;
          mid_cp  = {13'd0, byte_in};
        end else if (byte_in[7:5] == 3'b110) begin
          pend_new = 2'd1;
          exp_new  = 3'd2;
          cp_new   = {16'd0, byte_in[4:0]};
        end else if (byte_in[7:4] == 4'b1110) begin
          pend_new = 2'd1;
          exp_new  = 3'd3;
          cp_new   = {17'd0, byte_in[3:0]};
        end else if (byte_in[7:3] == 5'b11110) begin
          pend_new = 2'd1;
          exp_new  = 3'd4;
          cp_new   = {18'd0, byte_in[2:0]};
        end else begin
          has_mid = 1'b1;
          mid_cp  = {5'd0, REPL_CHAR};
        end
      end
      if (is_last) begin
        is_end = 1'b1;
      end
    end

    trail_cnt = (is_end && (byte_in != 8'h00)) ? pend_new : 2'd0;

    mid_bad    = (mid_cp > MAX_CP) || ((mid_cp >= SURR_FIRST) && (mid_cp <= SURR_LAST));
    mid_pair   = has_mid && !mid_bad && (mid_cp >= SUPP_BASE);
    mid_single = mid_bad ? REPL_CHAR : mid_cp[15:0];
    mid_len    = !has_mid ? 2'd0 : (mid_pair ? 2'd2 : 2'd1);
    supp       = 20'(mid_cp - SUPP_BASE);

    slot_n = {1'b0, lead_cnt} + {1'b0, mid_len} + {1'b0, trail_cnt};

    for (int i = 0; i < NSLOT; i++) begin
      idx = 3'(i);
      rel = idx - {1'b0, lead_cnt};
      slot_unit[i] = REPL_CHAR;
      slot_kind[i] = SK_SINGLE;
      if ((idx >= {1'b0, lead_cnt}) && (rel < {1'b0, mid_len})) begin
        if (mid_pair) begin
          if (rel == 3'd0) begin
            slot_unit[i] = {HI_SURR_TAG, supp[19:10]};
            slot_kind[i] = SK_HI;
          end else begin
            slot_unit[i] = {LO_SURR_TAG, supp[9:0]};
            slot_kind[i] = SK_LO;
          end
        end else begin
          slot_unit[i] = mid_single;
        end
      end
    end

    // apply the word limit in order; kept words always form a prefix
    cnt  = units_r;
    stp  = stop_r;
    kept = 3'd0;
    for (int i = 0; i < NSLOT; i++) begin
      if (3'(i) < slot_n) begin
        case (slot_kind[i])
          SK_HI: begin
            if (stp || (({1'b0, cnt} + 17'd2) > {1'b0, max_units})) begin
              stp = 1'b1;
            end else begin
              cnt  = cnt + 16'd1;
              kept = kept + 3'd1;
            end
          end
          SK_LO: begin
            if (!stp) begin
              cnt  = cnt + 16'd1;
              kept = kept + 3'd1;
            end
          end
          default: begin
            if (stp || (cnt >= max_units)) begin
              stp = 1'b1;
            end else begin
              cnt  = cnt + 16'd1;
              kept = kept + 3'd1;
            end
          end
        endcase
      end
    end

    for (int i = 0; i < NSLOT; i++) begin
      res[i].code_unit  = slot_unit[i];
      res[i].unit_valid = 1'b1;
      res[i].run_last   = (3'(i) + 3'd1 == kept);
      res[i].text_end   = is_end && (3'(i) + 3'd1 == kept);
    end
    res_cnt = kept;
    if (is_end && (kept == 3'd0)) begin
      // bare end marker
      res[0].code_unit  = 16'd0;
      res[0].unit_valid = 1'b0;
      res[0].run_last   = 1'b1;
      res[0].text_end   = 1'b1;
      res_cnt           = 3'd1;
    end

    if (is_end) begin
      pend_nxt  = 2'd0;
      exp_nxt   = 3'd0;
      cp_nxt    = 21'd0;
      units_nxt = 16'd0;
      stop_nxt  = 1'b0;
    end else begin
      pend_nxt  = pend_new;
      exp_nxt   = exp_new;
      cp_nxt    = cp_new;
      units_nxt = cnt;
      stop_nxt  = stp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      exp_r   <= 3'd0;
      cp_r    <= 21'd0;
      units_r <= 16'd0;
      stop_r  <= 1'b0;
    end else if (advance) begin
      pend_r  <= pend_nxt;
      exp_r   <= exp_nxt;
      cp_r    <= cp_nxt;
      units_r <= units_nxt;
      stop_r  <= stop_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_end) |=> (pend_r == 2'd0 && units_r == 16'd0 && !stop_r))
    else $error("decoder state not cleared after end of text");

  a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd0) |-> (exp_r > {1'b0, pend_r} && exp_r <= 3'd4))
    else $error("pending byte count out of range of sequence length");

  a_res_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> (res_cnt <= CNT_W'(NSLOT)))
    else $error("more result words than buffer slots");
`endif

endmodule

`default_nettype wire

// File: rtl/u8u16_outbuf.sv
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Result buffer: takes all words of one byte at once and hands them to the
// output port one per cycle while out_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outbuf (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire u8u16_pkg::res_vec_t          load_res,
  input  wire logic [u8u16_pkg::CNT_W-1:0]  load_cnt,
  output logic                              room,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output u8u16_pkg::res_t                   out_res
);

  import u8u16_pkg::*;

  res_vec_t           ent_r, ent_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_res    = ent_r[0];
  assign pop        = out_tvalid && out_tready;
  // free now, or the last word leaves this cycle
  assign room       = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = load_res;
      cnt_nxt = load_cnt;
    end else if (pop) begin
      ent_nxt = ent_r >> $bits(res_t);
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == '0 || (cnt_r == CNT_W'(1) && out_tready)))
    else $error("buffer loaded while words still wait");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NSLOT))
    else $error("buffer count out of range");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.text_end) |-> (out_res.run_last && cnt_r == CNT_W'(1)))
    else $error("text end not on the last word of its byte");
`endif

endmodule

`default_nettype wire

// File: rtl/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 transcoder. Takes one UTF-8 byte per word on the in_ port
// and gives UTF-16 code units on the out_ port, with tuser flagging real
// units and the last word of each byte, and tlast on the last word of a text.
// A byte is taken every cycle while out_tready is high and each byte yields
// at most one word; a byte that yields n words (up to four: flushed
// replacements, a surrogate pair) holds the result buffer while the out_ port
// drains one word per cycle when out_tready is high; the next byte waits in
// the input register. max_units is written through cfg_wr_en/cfg_wr_data;
// users must do so only while no text is in flight; the block does not check.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Top level: input register, sequence decoder, result buffer, limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] byte_in
  input  wire logic        in_tlast,    // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [15:0] code_unit
  output logic [1:0]       out_tuser,   // [0] unit_valid, [1] run_last
  output logic             out_tlast,   // text_end
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data  // max_units
);

  import u8u16_pkg::*;

  logic               in_vld_r, in_vld_nxt;
  logic [7:0]         byte_r;
  logic               last_r;
  logic [15:0]        max_units_r;
  logic               accept;
  logic               advance;
  logic               room;
  res_vec_t           dec_res;
  logic [CNT_W-1:0]   dec_cnt;
  res_t               out_res;

  assign advance   = in_vld_r && room;
  assign in_tready = !in_vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      max_units_r <= MAX_UNITS_RST;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        max_units_r <= cfg_wr_data;
      end
    end
  end

  u8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .byte_in   (byte_r),
    .is_last   (last_r),
    .max_units (max_units_r),
    .res       (dec_res),
    .res_cnt   (dec_cnt)
  );

  u8u16_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_res   (dec_res),
    .load_cnt   (dec_cnt),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.code_unit;
  assign out_tuser = {out_res.run_last, out_res.unit_valid};
  assign out_tlast = out_res.text_end;

endmodule

`default_nettype wire
